/* design/b32enc_pkg.sv */
package b32enc_pkg;

  localparam int unsigned GroupBits  = 40;
  localparam int unsigned CountW     = 3;
  localparam int unsigned WrapW      = 10;
  localparam int unsigned CharW      = 7;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CharW-1:0] PadChar     = 7'd61;
  localparam logic [CharW-1:0] NewlineChar = 7'd10;
  localparam logic [CountW-1:0] FullCount  = 3'd4;

  typedef struct packed {
    logic [GroupBits-1:0] bits;
    logic [CountW-1:0]    count;
    logic                 last;
  } group_t;

  function automatic logic [CharW-1:0] b32_char(input logic [4:0] idx);
    logic [CharW-1:0] res;
    if (idx < 5'd26) begin
      res = 7'd65 + {2'b00, idx};
    end else begin
      res = 7'd24 + {2'b00, idx};
    end
    return res;
  endfunction

endpackage

/* design/b32enc_if.sv */
interface b32enc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b32enc_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink (input valid, input out_char, input out_last, output ready);
endinterface

/* design/b32enc_front.sv */
module b32enc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  b32enc_byte_if.sink           byte_in,
  input  logic                  full_i,
  output logic                  push_o,
  output b32enc_pkg::group_t    push_data_o
);
  import b32enc_pkg::*;

  logic [GroupBits-1:0] bits_q, bits_d;
  logic [CountW-1:0]    count_q, count_d;
  logic [GroupBits-1:0] ins;
  logic                 fire;
  logic                 complete;

  assign byte_in.ready = !full_i;
  assign fire          = byte_in.valid && byte_in.ready;
  assign complete      = (count_q == FullCount) || byte_in.last_byte;

  always_comb begin
    ins = {byte_in.data_byte, 32'd0} >> {count_q, 3'b000};
    push_data_o.bits  = bits_q | ins;
    push_data_o.count = count_q + 3'd1;
    push_data_o.last  = byte_in.last_byte;
    push_o            = fire && complete;
  end

  always_comb begin
    bits_d  = bits_q;
    count_d = count_q;
    if (fire) begin
      if (complete) begin
        bits_d  = '0;
        count_d = '0;
      end else begin
        bits_d  = push_data_o.bits;
        count_d = push_data_o.count;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q  <= '0;
      count_q <= '0;
    end else begin
      bits_q  <= bits_d;
      count_q <= count_d;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("group count out of range");

endmodule

/* design/b32enc_queue.sv */
module b32enc_queue #(
  parameter int unsigned Depth = b32enc_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  b32enc_pkg::group_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output b32enc_pkg::group_t head_o,
  output logic               empty_o
);
  import b32enc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  group_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

/* design/b32enc_back.sv */
module b32enc_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [b32enc_pkg::WrapW-1:0]        line_wrap_i,
  input  b32enc_pkg::group_t                  head_i,
  input  logic                                empty_i,
  output logic                                pop_o,
  b32enc_char_if.source                       char_out
);
  import b32enc_pkg::*;

  logic             busy_q, busy_d;
  group_t           grp_q, grp_d;
  logic [2:0]       pos_q, pos_d;
  logic [WrapW-1:0] col_q, col_d;
  logic             ovalid_q, ovalid_d;
  logic [CharW-1:0] ochar_q, ochar_d;
  logic             olast_q, olast_d;

  logic             adv;
  logic             emit;
  logic             nl;
  logic             pad;
  logic             last_char;
  logic [5:0]       pos5;
  logic [5:0]       cnt8;

  assign char_out.valid    = ovalid_q;
  assign char_out.out_char = ochar_q;
  assign char_out.out_last = olast_q;

  always_comb begin
    adv       = !ovalid_q || char_out.ready;
    emit      = busy_q && adv;
    nl        = (line_wrap_i != '0) && (col_q >= line_wrap_i);
    pos5      = {1'b0, pos_q, 2'b00} + {3'b000, pos_q};
    cnt8      = {grp_q.count, 3'b000};
    pad       = pos5 >= cnt8;
    last_char = emit && !nl && (pos_q == 3'd7);
    pop_o     = !empty_i && (!busy_q || last_char);
  end

  always_comb begin
    busy_d   = busy_q;
    grp_d    = grp_q;
    pos_d    = pos_q;
    col_d    = col_q;
    ovalid_d = ovalid_q;
    ochar_d  = ochar_q;
    olast_d  = olast_q;
    if (emit) begin
      ovalid_d = 1'b1;
      if (nl) begin
        ochar_d = NewlineChar;
        olast_d = 1'b0;
        col_d   = '0;
      end else begin
        ochar_d    = pad ? PadChar : b32_char(grp_q.bits[GroupBits-1 -: 5]);
        olast_d    = grp_q.last && (pos_q == 3'd7);
        col_d      = col_q + WrapW'(1);
        pos_d      = pos_q + 3'd1;
        grp_d.bits = {grp_q.bits[GroupBits-6:0], 5'd0};
      end
    end else if (adv) begin
      ovalid_d = 1'b0;
    end
    if (last_char) begin
      busy_d = 1'b0;
      if (grp_q.last) begin
        col_d = '0;
      end
    end
    if (pop_o) begin
      busy_d = 1'b1;
      grp_d  = head_i;
      pos_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q   <= grp_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      pos_q    <= '0;
      col_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      pos_q    <= pos_d;
      col_q    <= col_d;
      ovalid_q <= ovalid_d;
    end
  end

  a_nl_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && ochar_q == NewlineChar) |-> !olast_q)
    else $error("newline beat marked last");

  a_col_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_char && grp_q.last) |=> col_q == '0)
    else $error("column not cleared at message end");

endmodule

/* design/base32_encode_with_wrap.sv */
// Channel   Dir  Handshake             Payload
// byte_in   in   valid/ready           data_byte[7:0], last_byte
// char_out  out  valid/ready           out_char[6:0], out_last
// cfg       in   cfg_we_i (no ready)   cfg_wdata_i[9:0] = line_wrap
//
// Output runs at one character per cycle while groups are queued and out is ready:
// the back end emits eight characters per group plus a newline beat at each wrap.
// Input takes one byte per cycle while the group queue has room.
// A byte's group leaves the front the cycle it completes; the first character is
// registered after the back end loads the group, and an output stall can hold it.
// Reset (rst_ni low, asynchronous) clears group, queue, column and line_wrap.
// Output stalls hold the back end; a full queue holds the input.
module base32_encode_with_wrap #(
  parameter int unsigned QueueDepth = b32enc_pkg::QueueDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [b32enc_pkg::WrapW-1:0]   cfg_wdata_i,
  b32enc_byte_if.sink                    byte_in,
  b32enc_char_if.source                  char_out
);
  import b32enc_pkg::*;

  logic [WrapW-1:0] line_wrap_q;
  logic             push;
  group_t           push_data;
  logic             full;
  logic             pop;
  group_t           head;
  logic             empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_wrap_q <= '0;
    end else if (cfg_we_i) begin
      line_wrap_q <= cfg_wdata_i;
    end
  end

  b32enc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_in     (byte_in),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  b32enc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  b32enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .line_wrap_i (line_wrap_q),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .char_out    (char_out)
  );

endmodule
